// ----- rtl/core/imu_bcs_pkg.sv -----
// package: shared types, widths and constants of the imu bias calibrate and scale core
package imu_bcs_pkg;

   localparam int NUM_AXES  = 6;
   localparam int NUM_ACCEL = 3;
   localparam int NUM_GYRO  = NUM_AXES - NUM_ACCEL;

   localparam int RAW_W     = 16;
   localparam int COR_W     = RAW_W + 1;
   localparam int ACC_OUT_W = 6;
   localparam int GYR_OUT_W = 12;

   localparam int RAW_SPAN    = 32768;
   localparam int OFFSET_MAX  = 32767;
   localparam int CAL_SAMPLES = 1000;

   localparam int SUM_W = $clog2(CAL_SAMPLES * RAW_SPAN) + 1;
   localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

   // mean by reciprocal multiply, exact for any magnitude below 2**SUM_W
   localparam int RECIP_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
   localparam int RECIP_W     = SUM_W + 1;
   localparam int MEAN_PROD_W = SUM_W + RECIP_W;
   localparam int QUO_W       = RAW_W + 1;
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

   localparam int GAIN       = 4;
   localparam int GAIN_SHIFT = $clog2(GAIN);
   localparam int ACCEL_DIV  = 16384;
   localparam int GYRO_DIV   = 131;

   localparam int ACCEL_SHIFT = $clog2(ACCEL_DIV) - GAIN_SHIFT;
   localparam int ACCEL_BIAS  = (1 << ACCEL_SHIFT) - 1;

   localparam int GYRO_N_W    = COR_W + GAIN_SHIFT;
   localparam int GYRO_SHIFT  = GYRO_N_W + $clog2(GYRO_DIV);
   localparam int GYRO_RECIP_W = GYRO_N_W + 1;
   localparam int GYRO_PROD_W = GYRO_N_W + GYRO_RECIP_W;
   localparam logic [GYRO_RECIP_W-1:0] GYRO_RECIP =
      GYRO_RECIP_W'(((64'd1 << GYRO_SHIFT) + 64'(GYRO_DIV) - 64'd1) / 64'(GYRO_DIV));

   typedef enum logic [1:0] {
      PH_CAL,
      PH_DIV_MUL,
      PH_DIV_FIX,
      PH_RUN
   } phase_type;

   typedef struct packed {
      logic accum;
      logic mul_en;
      logic fix_en;
      logic load;
   } lane_ctrl_type;

endpackage

// ----- rtl/core/imu_bcs_if.sv -----
// interfaces: request and response channels of the imu bias calibrate and scale core
interface imu_bcs_req_if import imu_bcs_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] accel_x;
   logic signed [RAW_W-1:0] accel_y;
   logic signed [RAW_W-1:0] accel_z;
   logic signed [RAW_W-1:0] gyro_x;
   logic signed [RAW_W-1:0] gyro_y;
   logic signed [RAW_W-1:0] gyro_z;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 output ready);
endinterface

interface imu_bcs_rsp_if import imu_bcs_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [ACC_OUT_W-1:0] accel_x_scaled;
   logic signed [ACC_OUT_W-1:0] accel_y_scaled;
   logic signed [ACC_OUT_W-1:0] accel_z_scaled;
   logic signed [GYR_OUT_W-1:0] gyro_x_scaled;
   logic signed [GYR_OUT_W-1:0] gyro_y_scaled;
   logic signed [GYR_OUT_W-1:0] gyro_z_scaled;

   modport source (output valid, accel_x_scaled, accel_y_scaled, accel_z_scaled,
                   gyro_x_scaled, gyro_y_scaled, gyro_z_scaled, input ready);
   modport sink (input valid, accel_x_scaled, accel_y_scaled, accel_z_scaled,
                 gyro_x_scaled, gyro_y_scaled, gyro_z_scaled, output ready);
endinterface

// ----- rtl/core/imu_bcs_lane.sv -----
// one axis lane: calibration sum, offset by reciprocal multiply, bias correction stage
module imu_bcs_lane import imu_bcs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  lane_ctrl_type           ctrl,
   input  logic signed [RAW_W-1:0] raw,
   output logic signed [COR_W-1:0] cor
);

   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [RAW_W-1:0]       offset_ff, offset_in;
   logic [MEAN_PROD_W-1:0]        prod_ff, prod_in;
   logic                          neg_ff;
   logic signed [COR_W-1:0]       cor_ff;
   logic [SUM_W-1:0]              mag;
   logic [QUO_W-1:0]              quo;

   assign sum_in  = sum_ff + SUM_W'(raw);
   assign mag     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign prod_in = MEAN_PROD_W'(mag) * MEAN_PROD_W'(MEAN_RECIP);
   assign quo     = QUO_W'(prod_ff >> RECIP_SHIFT);

   // negated mean, saturated where the mean is the most negative value
   always_comb begin
      if (neg_ff) begin
         if (quo > QUO_W'(OFFSET_MAX)) begin
            offset_in = RAW_W'(OFFSET_MAX);
         end else begin
            offset_in = RAW_W'(quo);
         end
      end else begin
         offset_in = RAW_W'(-quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         offset_ff <= '0;
      end else begin
         if (ctrl.accum) begin
            sum_ff <= sum_in;
         end
         if (ctrl.fix_en) begin
            offset_ff <= offset_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
         neg_ff  <= sum_ff[SUM_W-1];
      end
      if (ctrl.load) begin
         cor_ff <= COR_W'(raw) + COR_W'(offset_ff);
      end
   end

   assign cor = cor_ff;

endmodule

// ----- rtl/core/imu_bcs_merge.sv -----
// merge stage: per-axis scaling of the corrected lanes and the response register
module imu_bcs_merge import imu_bcs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [COR_W-1:0] cor [NUM_AXES],
   imu_bcs_rsp_if.source           rsp_bus
);

   logic                          b_valid_ff, b_valid_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          b_ready, c_ready;

   logic signed [ACC_OUT_W-1:0]   acc_in [NUM_ACCEL];
   logic signed [ACC_OUT_W-1:0]   acc_ff [NUM_ACCEL];
   logic [GYRO_PROD_W-1:0]        gprod_in [NUM_GYRO];
   logic [GYRO_PROD_W-1:0]        gprod_ff [NUM_GYRO];
   logic                          gneg_ff [NUM_GYRO];
   logic signed [ACC_OUT_W-1:0]   acc_out_ff [NUM_ACCEL];
   logic signed [GYR_OUT_W-1:0]   gyr_out_in [NUM_GYRO];
   logic signed [GYR_OUT_W-1:0]   gyr_out_ff [NUM_GYRO];

   assign c_ready  = !out_valid_ff || rsp_bus.ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign in_ready = b_ready;

   assign b_valid_in   = b_ready ? in_valid : b_valid_ff;
   assign out_valid_in = c_ready ? b_valid_ff : out_valid_ff;

   // accel: shift with round toward zero
   always_comb begin
      logic signed [COR_W-1:0] biased;
      logic signed [COR_W-1:0] shifted;
      for (int i = 0; i < NUM_ACCEL; i++) begin
         biased    = cor[i] + (cor[i][COR_W-1] ? COR_W'(ACCEL_BIAS) : COR_W'(0));
         shifted   = biased >>> ACCEL_SHIFT;
         acc_in[i] = shifted[ACC_OUT_W-1:0];
      end
   end

   // gyro: magnitude times gain, then reciprocal multiply
   always_comb begin
      logic [COR_W-1:0]    gmag;
      logic [GYRO_N_W-1:0] gnum;
      for (int g = 0; g < NUM_GYRO; g++) begin
         gmag = cor[NUM_ACCEL+g][COR_W-1] ? COR_W'(-cor[NUM_ACCEL+g])
                                          : COR_W'(cor[NUM_ACCEL+g]);
         gnum = {gmag, GAIN_SHIFT'(0)};
         gprod_in[g] = GYRO_PROD_W'(gnum) * GYRO_PROD_W'(GYRO_RECIP);
      end
   end

   always_comb begin
      logic [GYR_OUT_W-1:0] q;
      for (int g = 0; g < NUM_GYRO; g++) begin
         q = GYR_OUT_W'(gprod_ff[g] >> GYRO_SHIFT);
         gyr_out_in[g] = gneg_ff[g] ? GYR_OUT_W'(-q) : GYR_OUT_W'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         for (int i = 0; i < NUM_ACCEL; i++) begin
            acc_ff[i] <= acc_in[i];
         end
         for (int g = 0; g < NUM_GYRO; g++) begin
            gprod_ff[g] <= gprod_in[g];
            gneg_ff[g]  <= cor[NUM_ACCEL+g][COR_W-1];
         end
      end
      if (c_ready) begin
         for (int i = 0; i < NUM_ACCEL; i++) begin
            acc_out_ff[i] <= acc_ff[i];
         end
         for (int g = 0; g < NUM_GYRO; g++) begin
            gyr_out_ff[g] <= gyr_out_in[g];
         end
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.accel_x_scaled = acc_out_ff[0];
   assign rsp_bus.accel_y_scaled = acc_out_ff[1];
   assign rsp_bus.accel_z_scaled = acc_out_ff[2];
   assign rsp_bus.gyro_x_scaled  = gyr_out_ff[0];
   assign rsp_bus.gyro_y_scaled  = gyr_out_ff[1];
   assign rsp_bus.gyro_z_scaled  = gyr_out_ff[2];

endmodule

// ----- rtl/core/imu_bias_calibrate_and_scale_core.sv -----
// top level: six-axis imu bias calibration and scaling core
//
// After reset the core takes the first CAL_SAMPLES requests (1000) one per cycle and returns
// nothing for them while six lanes sum each axis. The request after the last calibration
// sample is held off in the PH_DIV_MUL and PH_DIV_FIX states while each lane turns its sum into
// an offset through a registered reciprocal multiply. From then on every request gives one
// response: one request per cycle sustained, through the correction stage, the scaling multiply
// stage and the response register, with ready falling only when the response is not taken.
module imu_bias_calibrate_and_scale_core import imu_bcs_pkg::*; (
   input logic          clock,
   input logic          reset,
   imu_bcs_req_if.sink  req_bus,
   imu_bcs_rsp_if.source rsp_bus
);

   phase_type               phase_ff, phase_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    a_valid_ff, a_valid_in;
   logic                    a_ready, merge_ready;
   logic                    req_ready;
   logic                    accept, last;
   lane_ctrl_type           ctrl;
   logic signed [RAW_W-1:0] raw [NUM_AXES];
   logic signed [COR_W-1:0] cor [NUM_AXES];

   assign raw[0] = req_bus.accel_x;
   assign raw[1] = req_bus.accel_y;
   assign raw[2] = req_bus.accel_z;
   assign raw[3] = req_bus.gyro_x;
   assign raw[4] = req_bus.gyro_y;
   assign raw[5] = req_bus.gyro_z;

   assign accept        = req_bus.valid && req_ready;
   assign last          = (cnt_ff == CNT_W'(CAL_SAMPLES - 1));
   assign a_ready       = !a_valid_ff || merge_ready;
   assign req_bus.ready = req_ready;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_CAL: begin
            if (accept && last) begin
               phase_in = PH_DIV_MUL;
            end
         end
         PH_DIV_MUL: phase_in = PH_DIV_FIX;
         PH_DIV_FIX: phase_in = PH_RUN;
         PH_RUN:     phase_in = PH_RUN;
         default:    phase_in = PH_CAL;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctrl      = '0;
      unique case (phase_ff)
         PH_CAL: begin
            req_ready  = 1'b1;
            ctrl.accum = req_bus.valid;
         end
         PH_DIV_MUL: ctrl.mul_en = 1'b1;
         PH_DIV_FIX: ctrl.fix_en = 1'b1;
         PH_RUN: begin
            req_ready = a_ready;
            ctrl.load = a_ready;
         end
         default: begin
            req_ready = 1'b0;
            ctrl      = '0;
         end
      endcase
   end

   assign cnt_in     = (phase_ff == PH_CAL && accept && !last) ? cnt_ff + 1'b1 : cnt_ff;
   assign a_valid_in = a_ready ? (phase_ff == PH_RUN && accept) : a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_CAL;
         cnt_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         a_valid_ff <= a_valid_in;
      end
   end

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      imu_bcs_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .raw   (raw[i]),
         .cor   (cor[i])
      );
   end

   imu_bcs_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (a_valid_ff),
      .in_ready (merge_ready),
      .cor      (cor),
      .rsp_bus  (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   a_hold_off_during_divide: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIV_MUL || phase_ff == PH_DIV_FIX) |-> !req_bus.ready)
      else $error("request taken while offsets are computed");

   a_no_response_before_run: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_RUN) |-> (!rsp_bus.valid && !a_valid_ff))
      else $error("response pending during calibration");

   a_last_sample_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CAL && accept && last) |=> (phase_ff == PH_DIV_MUL))
      else $error("calibration did not end on the last sample");

   a_fix_then_run: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIV_FIX) |=> (phase_ff == PH_RUN && $stable(cnt_ff)))
      else $error("offset fix not followed by run");
`endif

endmodule
